/* sv/swhc_pkg.sv */
package swhc_pkg;

  localparam int unsigned TIME_W    = 40;
  localparam int unsigned MOIST_W   = 16;
  localparam int unsigned THR_W     = 10;
  localparam int unsigned SOAK_W    = 16;
  localparam int unsigned DUR_W     = 9;
  localparam int unsigned STALE_W   = 22;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned MS_PER_S = 1000;

  // Soak interval kept in milliseconds: 65535 s * 1000 fits in 26 bits.
  localparam int unsigned SOAK_MS_W = 26;

  // Valid range of a soil reading, bounds included.
  localparam logic signed [MOIST_W-1:0] MOISTURE_MIN = 16'sd0;
  localparam logic signed [MOIST_W-1:0] MOISTURE_MAX = 16'sd1000;

  localparam int unsigned PUMP_CAP_S_DEF = 300;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WATERING_EN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOAK_S      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_S     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_MS    = 3'd5;

  // Configuration reset values.
  localparam logic [THR_W-1:0]     LOW_THR_RST  = 10'd300;
  localparam logic [THR_W-1:0]     HIGH_THR_RST = 10'd600;
  localparam int unsigned          SOAK_S_RST   = 600;
  localparam int unsigned          BURST_S_RST  = 30;
  localparam logic [STALE_W-1:0]   STALE_MS_RST = 22'd300000;

  typedef enum logic [1:0] {
    FS_NONE        = 2'd0,
    FS_UNAVAILABLE = 2'd1,
    FS_INVALID     = 2'd2,
    FS_STALE       = 2'd3
  } fs_reason_t;

  typedef struct packed {
    logic [TIME_W-1:0]         now_ms;
    logic                      read_ok;
    logic                      sensor_available;
    logic signed [MOIST_W-1:0] moisture_tenths;
  } in_item_t;

  typedef struct packed {
    logic       pump_on;
    logic       burst_started;
    fs_reason_t failsafe_reason;
  } out_item_t;

  typedef struct packed {
    logic                 watering_en;
    logic [THR_W-1:0]     low_thr;
    logic [THR_W-1:0]     high_thr;
    logic [SOAK_MS_W-1:0] soak_ms;
    logic [STALE_W-1:0]   stale_ms;
  } cfg_t;

  typedef struct packed {
    logic              pump_running;
    logic [TIME_W-1:0] pump_stop_time;
    logic              burst_active;
    logic              have_valid_read;
    logic [TIME_W-1:0] last_valid_time;
    logic              have_burst_end;
    logic [TIME_W-1:0] last_burst_end_time;
  } ctrl_state_t;

endpackage

/* sv/swhc_in_if.sv */
interface swhc_in_if import swhc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [TIME_W-1:0]         now_ms;
  logic                      read_ok;
  logic                      sensor_available;
  logic signed [MOIST_W-1:0] moisture_tenths;

  modport source (
    output valid, now_ms, read_ok, sensor_available, moisture_tenths,
    input  ready
  );
  modport sink (
    input  valid, now_ms, read_ok, sensor_available, moisture_tenths,
    output ready
  );
endinterface

/* sv/swhc_out_if.sv */
interface swhc_out_if import swhc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       pump_on;
  logic       burst_started;
  logic [1:0] failsafe_reason;

  modport source (
    output valid, pump_on, burst_started, failsafe_reason,
    input  ready
  );
  modport sink (
    input  valid, pump_on, burst_started, failsafe_reason,
    output ready
  );
endinterface

/* sv/swhc_cfg_if.sv */
interface swhc_cfg_if import swhc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (
    output valid, reg_index, wdata,
    input  ready
  );
  modport sink (
    input  valid, reg_index, wdata,
    output ready
  );
endinterface

/* sv/swhc_step.sv */
module swhc_step import swhc_pkg::*; #(
  parameter int unsigned DUR_MS_W = 19
) (
  input  ctrl_state_t         cur,
  input  cfg_t                cfg,
  input  logic [DUR_MS_W-1:0] dur_ms,
  input  in_item_t            item,
  output ctrl_state_t         nxt,
  output out_item_t           res
);

  ctrl_state_t       st;
  logic              started;
  fs_reason_t        reason;
  fs_reason_t        fs;
  logic              in_range;
  logic              invalid;
  logic              stale;
  logic              soaked;
  logic [TIME_W-1:0] age_valid;
  logic [TIME_W-1:0] age_end;
  logic [TIME_W:0]   stop_sum;

  always_comb begin
    st        = cur;
    started   = 1'b0;
    reason    = FS_NONE;
    fs        = FS_NONE;
    in_range  = (item.moisture_tenths >= MOISTURE_MIN) &&
                (item.moisture_tenths <= MOISTURE_MAX);
    invalid   = item.read_ok && !in_range;
    stale     = 1'b0;
    soaked    = 1'b0;
    age_valid = '0;
    age_end   = '0;
    stop_sum  = '0;

    // The pump timer runs out at the first tick at or past the stop time.
    if (st.pump_running && (item.now_ms >= st.pump_stop_time)) begin
      st.pump_running = 1'b0;
    end
    if (st.burst_active && !st.pump_running) begin
      st.last_burst_end_time = item.now_ms;
      st.have_burst_end      = 1'b1;
      st.burst_active        = 1'b0;
    end

    if (cfg.watering_en) begin
      if (item.read_ok && in_range) begin
        st.last_valid_time = item.now_ms;
        st.have_valid_read = 1'b1;
      end
      // Time running backwards counts as no time elapsed.
      if (item.now_ms >= st.last_valid_time) begin
        age_valid = item.now_ms - st.last_valid_time;
      end
      stale = !st.have_valid_read || (age_valid > TIME_W'(cfg.stale_ms));

      if (!item.sensor_available) begin
        fs = FS_UNAVAILABLE;
      end else if (invalid) begin
        fs = FS_INVALID;
      end else if (stale) begin
        fs = FS_STALE;
      end

      if (fs != FS_NONE) begin
        if (st.pump_running) begin
          st.pump_running = 1'b0;
          reason          = fs;
        end
        st.burst_active = 1'b0;
      end else if (item.read_ok) begin
        if (st.pump_running) begin
          if (item.moisture_tenths >= $signed({6'b0, cfg.high_thr})) begin
            st.pump_running        = 1'b0;
            st.last_burst_end_time = item.now_ms;
            st.have_burst_end      = 1'b1;
            st.burst_active        = 1'b0;
          end
        end else if (item.moisture_tenths <= $signed({6'b0, cfg.low_thr})) begin
          if (item.now_ms >= st.last_burst_end_time) begin
            age_end = item.now_ms - st.last_burst_end_time;
          end
          soaked   = !st.have_burst_end || (age_end >= TIME_W'(cfg.soak_ms));
          stop_sum = {1'b0, item.now_ms} + (TIME_W+1)'(dur_ms);
          if (soaked && (dur_ms != '0)) begin
            // The stop time saturates at the top of the time range.
            st.pump_stop_time = stop_sum[TIME_W] ? '1 : stop_sum[TIME_W-1:0];
            st.pump_running   = 1'b1;
            st.burst_active   = 1'b1;
            started           = 1'b1;
          end
        end
      end
    end

    nxt                 = st;
    res.pump_on         = st.pump_running;
    res.burst_started   = started;
    res.failsafe_reason = reason;
  end

endmodule

/* sv/soil_watering_hysteresis_control_core.sv */
// Soil watering controller with hysteresis, a modeled pump timer and fail-safe.
//
// in_ch carries one tick per transaction: timestamp in ms, read status, sensor
// presence and signed moisture in tenths of a percent. out_ch returns exactly
// one result per tick: pump state after the tick, a burst-start flag and the
// fail-safe reason when a running pump was stopped by a bad reading.
// cfg_ch writes one register per transaction (index 0 enable, 1 low threshold,
// 2 high threshold, 3 soak seconds, 4 burst seconds, 5 staleness ms); other
// indexes are ignored. It is always ready and should be used while idle.
//
// A tick is captured in an input register, evaluated combinationally against the
// controller state and lands in the output register, from which out_ch takes
// it; throughput is one tick per cycle while the receiver does not stall.
// When the receiver stalls, the result holds in the output register, one more
// tick waits in the input register, and in_ch.ready drops after that.
// Synchronous reset clears the pump and burst state and loads the register
// defaults; no clearing pass is needed, so ticks are taken right after reset.
module soil_watering_hysteresis_control_core import swhc_pkg::*; #(
  parameter int unsigned PUMP_CAP_S = PUMP_CAP_S_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  swhc_cfg_if.sink       cfg_ch,
  swhc_in_if.sink        in_ch,
  swhc_out_if.source     out_ch
);

  localparam int unsigned DUR_MS_MAX = PUMP_CAP_S * MS_PER_S;
  localparam int unsigned DUR_MS_W   = $clog2(DUR_MS_MAX + 1);
  localparam int unsigned BURST_CAP_RST =
    (BURST_S_RST > PUMP_CAP_S) ? PUMP_CAP_S : BURST_S_RST;
  localparam logic [DUR_MS_W-1:0]  DUR_MS_RST  = DUR_MS_W'(BURST_CAP_RST * MS_PER_S);
  localparam logic [SOAK_MS_W-1:0] SOAK_MS_RST = SOAK_MS_W'(SOAK_S_RST * MS_PER_S);

  // Configuration registers; time values are kept in milliseconds.
  cfg_t                cfg_r;
  logic [DUR_MS_W-1:0] dur_ms_r;
  logic [DUR_W-1:0]    burst_s;
  logic [DUR_W-1:0]    burst_s_capped;

  // Pipeline and controller state.
  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  out_item_t   res_nxt;
  logic        adv;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    burst_s        = cfg_ch.wdata[DUR_W-1:0];
    burst_s_capped = burst_s;
    if (32'(burst_s) > PUMP_CAP_S) begin
      burst_s_capped = DUR_W'(PUMP_CAP_S);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.watering_en <= 1'b0;
      cfg_r.low_thr     <= LOW_THR_RST;
      cfg_r.high_thr    <= HIGH_THR_RST;
      cfg_r.soak_ms     <= SOAK_MS_RST;
      cfg_r.stale_ms    <= STALE_MS_RST;
      dur_ms_r          <= DUR_MS_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.reg_index)
        REG_WATERING_EN: cfg_r.watering_en <= cfg_ch.wdata[0];
        REG_LOW_THR:     cfg_r.low_thr     <= cfg_ch.wdata[THR_W-1:0];
        REG_HIGH_THR:    cfg_r.high_thr    <= cfg_ch.wdata[THR_W-1:0];
        REG_SOAK_S:      cfg_r.soak_ms     <=
          SOAK_MS_W'(32'(cfg_ch.wdata[SOAK_W-1:0]) * 32'(MS_PER_S));
        REG_BURST_S:     dur_ms_r          <=
          DUR_MS_W'(32'(burst_s_capped) * 32'(MS_PER_S));
        REG_STALE_MS:    cfg_r.stale_ms    <= cfg_ch.wdata[STALE_W-1:0];
        default: ;
      endcase
    end
  end

  // The evaluated tick moves on when the output register is free or drains.
  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.now_ms           <= in_ch.now_ms;
      s1_item_r.read_ok          <= in_ch.read_ok;
      s1_item_r.sensor_available <= in_ch.sensor_available;
      s1_item_r.moisture_tenths  <= in_ch.moisture_tenths;
    end
  end

  swhc_step #(
    .DUR_MS_W (DUR_MS_W)
  ) u_step (
    .cur    (state_r),
    .cfg    (cfg_r),
    .dur_ms (dur_ms_r),
    .item   (s1_item_r),
    .nxt    (state_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.pump_on         = out_item_r.pump_on;
  assign out_ch.burst_started   = out_item_r.burst_started;
  assign out_ch.failsafe_reason = out_item_r.failsafe_reason;

  // A fail-safe stop always leaves the pump off.
  a_failsafe_pump_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.failsafe_reason != FS_NONE) |-> !out_item_r.pump_on)
    else $error("fail-safe reported while pump still on");

  // A burst that starts leaves the pump running.
  a_start_pump_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.burst_started |-> out_item_r.pump_on)
    else $error("burst started without pump on");

  // The pump only runs inside an active burst.
  a_running_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pump_running |-> state_r.burst_active)
    else $error("pump running outside a burst");

  // Every evaluated tick produces a result in the next cycle.
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("evaluated tick lost its result");

endmodule
